### hw/rtl/kfm_pkg.sv
// Package with action codes and fixed constants of the key to function mapper.
`timescale 1ns / 1ps
package kfm_pkg;
   localparam logic [2:0] ACT_REPORT_START = 3'd0;
   localparam logic [2:0] ACT_REPORT_KEY   = 3'd1;
   localparam logic [2:0] ACT_DISCONNECT   = 3'd2;
   localparam logic [2:0] ACT_TICK         = 3'd3;
   localparam logic [2:0] ACT_COLLECT      = 3'd4;
   localparam logic [2:0] ACT_QUERY_HELD   = 3'd5;
   localparam logic [2:0] ACT_WRITE_BIND   = 3'd6;

   localparam int KEY_BITS       = 256;
   localparam int MOD_BASE       = 8'hE0;
   localparam logic [7:0] SENTINEL_MAX = 8'h03;
   localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
   localparam int FN_TEST        = 6;
   localparam int FN_COIN        = 7;
   localparam int HIT_FUNCTIONS  = 4;

   typedef logic [KEY_BITS-1:0] bitmap_type;
endpackage

### hw/rtl/key_to_function_mapper.sv
// Top level of the key to function mapper: port bitmaps, binding memory and tick walker.
// Collect and query answer with rsp_valid in the cycle after the start beat.
// A tick walks PLAYERS*FUNCTIONS*BINDS_PER_FUNCTION binding entries at one memory
// read a cycle. Reset clears the bitmaps and counters; then a clearing pass unbinds
// all PLAYERS*FUNCTIONS*BINDS_PER_FUNCTION entries while busy stays high.
// Results are strobes; the receiver cannot stall them.
`timescale 1ns / 1ps
module key_to_function_mapper
   import kfm_pkg::*;
#(
   parameter int KEY_PORTS          = 4,
   parameter int PLAYERS            = 2,
   parameter int BINDS_PER_FUNCTION = 6,
   parameter int FUNCTIONS          = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_action,
   input  logic [1:0]  req_port,
   input  logic [7:0]  req_modifiers,
   input  logic        req_has_keys,
   input  logic [7:0]  req_keycode,
   input  logic        req_player,
   input  logic [3:0]  req_pad_function,
   input  logic [2:0]  req_slot,
   output logic        rsp_valid,
   output logic [9:0]  rsp_level_first,
   output logic [9:0]  rsp_level_second,
   output logic [3:0]  rsp_hits_first,
   output logic [3:0]  rsp_hits_second,
   output logic [15:0] rsp_coin_count,
   output logic [15:0] rsp_test_count,
   output logic        rsp_held
);
   localparam int DEPTH = PLAYERS * FUNCTIONS * BINDS_PER_FUNCTION;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;
   localparam int FW = $clog2(FUNCTIONS);
   localparam int SW = (BINDS_PER_FUNCTION > 1) ? $clog2(BINDS_PER_FUNCTION) : 1;
   localparam int RW = $clog2(BINDS_PER_FUNCTION + 1);
   localparam int SECOND = (PLAYERS > 1) ? 1 : 0;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_WALK  = 2'd2;
   localparam logic [1:0] ST_DRAIN = 2'd3;

   logic [1:0]  state_ff, state_in;
   bitmap_type  port_keys_ff [KEY_PORTS];
   bitmap_type  prev_keys_ff;
   bitmap_type  cur_keys;
   logic [7:0]  bind_mem [DEPTH];
   logic [7:0]  rdata_ff;

   logic [AW-1:0] addr_ff;
   logic [PW-1:0] p_ff;
   logic [FW-1:0] f_ff;
   logic [SW-1:0] s_ff;
   logic          ev_valid_ff, ev_last_ff, ev_slot_last_ff, ev_fn_last_ff;
   logic [PW-1:0] ev_p_ff;
   logic [FW-1:0] ev_f_ff;

   logic          any_ff, stop_ff;
   logic [RW-1:0] rises_ff;
   logic [FUNCTIONS-1:0] lvl_acc_ff;
   logic [FUNCTIONS-1:0] level_ff [PLAYERS];
   logic [HIT_FUNCTIONS-1:0] hits_ff [PLAYERS];
   logic [15:0]   coin_ff, test_ff;

   logic accept;
   logic port_ok;
   logic bind_ok;
   logic [AW-1:0] bind_addr;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;

   logic          ev_live, ev_hit, ev_rise, any_n;
   logic [RW-1:0] rises_n;
   logic [16:0]   coin_sum, test_sum;

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign port_ok = (32'(req_port) < KEY_PORTS);
   assign bind_ok = (32'(req_player) < PLAYERS) && (32'(req_pad_function) < FUNCTIONS)
                    && (32'(req_slot) < BINDS_PER_FUNCTION);
   assign bind_addr = AW'((32'(req_player) * FUNCTIONS + 32'(req_pad_function))
                          * BINDS_PER_FUNCTION + 32'(req_slot));

   always_comb begin
      cur_keys = '0;
      for (int i = 0; i < KEY_PORTS; i++) begin
         cur_keys = cur_keys | port_keys_ff[i];
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = '0;
      if (state_ff == ST_CLEAR) begin
         mem_we = 1'b1;
      end else if (accept && req_action == ACT_WRITE_BIND && bind_ok) begin
         mem_we    = 1'b1;
         mem_waddr = bind_addr;
         mem_wdata = req_keycode;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bind_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= bind_mem[addr_ff];
   end

   // Evaluation of the entry read in the previous cycle; a zero code ends the list.
   assign ev_live  = !stop_ff && (rdata_ff != 8'd0);
   assign ev_hit   = ev_live && cur_keys[rdata_ff];
   assign ev_rise  = ev_hit && !prev_keys_ff[rdata_ff];
   assign any_n    = any_ff | ev_hit;
   assign rises_n  = rises_ff + RW'(ev_rise);
   assign coin_sum = {1'b0, coin_ff} + 17'(rises_n);
   assign test_sum = {1'b0, test_ff} + 17'(rises_n);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (addr_ff == AW'(DEPTH - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (accept && req_action == ACT_TICK) state_in = ST_WALK;
         ST_WALK:  if (addr_ff == AW'(DEPTH - 1)) state_in = ST_DRAIN;
         ST_DRAIN: if (ev_valid_ff && ev_last_ff) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         p_ff         <= '0;
         f_ff         <= '0;
         s_ff         <= '0;
         ev_valid_ff  <= 1'b0;
         any_ff       <= 1'b0;
         stop_ff      <= 1'b0;
         rises_ff     <= '0;
         lvl_acc_ff   <= '0;
         prev_keys_ff <= '0;
         coin_ff      <= '0;
         test_ff      <= '0;
         rsp_valid    <= 1'b0;
         for (int i = 0; i < KEY_PORTS; i++) port_keys_ff[i] <= '0;
         for (int i = 0; i < PLAYERS; i++) begin
            level_ff[i] <= '0;
            hits_ff[i]  <= '0;
         end
      end else begin
         state_ff    <= state_in;
         rsp_valid   <= accept && (req_action == ACT_COLLECT || req_action == ACT_QUERY_HELD);
         ev_valid_ff <= (state_ff == ST_WALK);

         if (state_ff == ST_CLEAR || state_ff == ST_WALK) begin
            addr_ff <= (addr_ff == AW'(DEPTH - 1)) ? '0 : addr_ff + AW'(1);
         end
         if (state_ff == ST_WALK) begin
            ev_p_ff         <= p_ff;
            ev_f_ff         <= f_ff;
            ev_slot_last_ff <= (s_ff == SW'(BINDS_PER_FUNCTION - 1));
            ev_fn_last_ff   <= (f_ff == FW'(FUNCTIONS - 1));
            ev_last_ff      <= (addr_ff == AW'(DEPTH - 1));
            if (s_ff == SW'(BINDS_PER_FUNCTION - 1)) begin
               s_ff <= '0;
               if (f_ff == FW'(FUNCTIONS - 1)) begin
                  f_ff <= '0;
                  p_ff <= (p_ff == PW'(PLAYERS - 1)) ? '0 : p_ff + PW'(1);
               end else begin
                  f_ff <= f_ff + FW'(1);
               end
            end else begin
               s_ff <= s_ff + SW'(1);
            end
         end

         if (ev_valid_ff) begin
            if (ev_slot_last_ff) begin
               any_ff   <= 1'b0;
               stop_ff  <= 1'b0;
               rises_ff <= '0;
               if (32'(ev_f_ff) < HIT_FUNCTIONS && rises_n != '0) begin
                  hits_ff[ev_p_ff][ev_f_ff[1:0]] <= 1'b1;
               end
               if (ev_f_ff == FW'(FN_COIN)) begin
                  coin_ff <= coin_sum[16] ? COUNT_MAX : coin_sum[15:0];
               end
               if (ev_f_ff == FW'(FN_TEST)) begin
                  test_ff <= test_sum[16] ? COUNT_MAX : test_sum[15:0];
               end
               if (ev_fn_last_ff) begin
                  level_ff[ev_p_ff] <= lvl_acc_ff | (FUNCTIONS'(any_n) << ev_f_ff);
                  lvl_acc_ff        <= '0;
               end else begin
                  lvl_acc_ff <= lvl_acc_ff | (FUNCTIONS'(any_n) << ev_f_ff);
               end
            end else begin
               any_ff   <= any_n;
               stop_ff  <= stop_ff | (rdata_ff == 8'd0);
               rises_ff <= rises_n;
            end
            if (ev_last_ff) begin
               prev_keys_ff <= cur_keys;
            end
         end

         if (accept) begin
            case (req_action)
               ACT_REPORT_START: begin
                  if (port_ok && (req_has_keys || req_modifiers != 8'd0)) begin
                     port_keys_ff[req_port] <= bitmap_type'({req_modifiers, MOD_BASE'(0)});
                  end
               end
               ACT_REPORT_KEY: begin
                  if (port_ok && req_keycode > SENTINEL_MAX) begin
                     port_keys_ff[req_port][req_keycode] <= 1'b1;
                  end
               end
               ACT_DISCONNECT: begin
                  if (port_ok) port_keys_ff[req_port] <= '0;
               end
               ACT_TICK: begin
                  addr_ff <= '0;
                  p_ff    <= '0;
                  f_ff    <= '0;
                  s_ff    <= '0;
               end
               ACT_COLLECT: begin
                  rsp_level_first  <= level_ff[0][9:0];
                  rsp_level_second <= (PLAYERS > 1) ? level_ff[SECOND][9:0] : 10'd0;
                  rsp_hits_first   <= hits_ff[0];
                  rsp_hits_second  <= (PLAYERS > 1) ? hits_ff[SECOND] : 4'd0;
                  rsp_coin_count   <= coin_ff;
                  rsp_test_count   <= test_ff;
                  rsp_held         <= 1'b0;
                  for (int i = 0; i < PLAYERS; i++) hits_ff[i] <= '0;
                  coin_ff <= '0;
                  test_ff <= '0;
               end
               ACT_QUERY_HELD: begin
                  rsp_level_first  <= '0;
                  rsp_level_second <= '0;
                  rsp_hits_first   <= '0;
                  rsp_hits_second  <= '0;
                  rsp_coin_count   <= '0;
                  rsp_test_count   <= '0;
                  rsp_held         <= cur_keys[req_keycode];
               end
               default: begin
               end
            endcase
         end
      end
   end
endmodule
